@@ rtl/cmnc_pkg.sv @@
// ----------------------------------------------------------------------------
// cmnc_pkg: shared types and constants
// Table geometry, command codes and table entry layout for the contour
// neighbor cost block.
// ----------------------------------------------------------------------------
package cmnc_pkg;

   localparam int PT_COUNT = 1024;
   localparam int IDX_W    = $clog2(PT_COUNT);
   localparam int SIZE_W   = IDX_W + 1;
   localparam int CNT_W    = $clog2(IDX_W);

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_ADJ   = 2'd1,
      CMD_BACK  = 2'd2,
      CMD_FWD   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] target;
   } ent_type;

endpackage

@@ rtl/cmnc_rem_unit.sv @@
// ----------------------------------------------------------------------------
// cmnc_rem_unit: iterative remainder
// Restoring shift-subtract remainder of an index by the ring size, one
// dividend bit per cycle. done pulses one cycle with the remainder held.
// ----------------------------------------------------------------------------
module cmnc_rem_unit import cmnc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IDX_W-1:0]  dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [IDX_W-1:0]  remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  sh_ff, sh_in;
   logic [SIZE_W-1:0] div_ff, div_in;
   logic [SIZE_W-1:0] trial;

   assign trial = {rem_ff, sh_ff[IDX_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         sh_in   = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[IDX_W-2:0], 1'b0};
         rem_in = (trial >= div_ff) ? IDX_W'(trial - div_ff) : IDX_W'(trial);
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(IDX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/contour_mapping_neighbor_cost.sv @@
// ----------------------------------------------------------------------------
// contour_mapping_neighbor_cost: contour neighbor cost engine
// Keeps a source-to-target point mapping table and answers cost queries
// against the mapping of a source point's ring neighbors.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: start while busy is low. Command write stores one table
//   entry in that cycle and gives no result; busy stays low, so another
//   beat may follow at once. Adjacent, backward and forward queries raise
//   busy and give one rsp_valid strobe with rsp_cost, one cycle wide, in
//   the first cycle after busy falls; a new beat may be taken in that cycle.
//   Queries: every query first reduces both indexes modulo the ring size
//   (one bit per cycle in the shared remainder unit), and each mapped entry
//   that is scored is reduced the same way before its cost is added.
//   Adjacent: scores the mapped entries on both sides of the source.
//   Backward/forward: one table read per ring step until the first mapped
//   entry is found; the cost is zero when nothing is mapped.
//   csr_ring_size is taken whenever csr_valid is high (csr_ready is tied
//   high) and is latched by each query when it starts.
//   Reset: ring size goes to 1024 and a clearing pass marks all 1024 table
//   entries unmapped, one per cycle; busy is high during the clearing pass.
//   The receiver takes every result beat and cannot stall the block.
// ----------------------------------------------------------------------------
module contour_mapping_neighbor_cost import cmnc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic [IDX_W-1:0]  req_source_index,
   input  logic [IDX_W-1:0]  req_target_index,
   input  logic              req_entry_mapped,
   input  logic [IDX_W-1:0]  req_entry_target,
   output logic              rsp_valid,
   output logic [SIZE_W-1:0] rsp_cost,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_ring_size
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD_SRC,
      ST_MOD_TGT,
      ST_ADJ_RD0,
      ST_ADJ_CHK0,
      ST_ADJ_RD1,
      ST_ADJ_CHK1,
      ST_SEARCH,
      ST_MOD_ENT,
      ST_COST_RD,
      ST_COST_ACC
   } state_type;

   function automatic logic [IDX_W-1:0] ring_back(input logic [IDX_W-1:0]  i,
                                                  input logic [SIZE_W-1:0] s);
      return (i == '0) ? IDX_W'(s - SIZE_W'(1)) : i - IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_fwd(input logic [IDX_W-1:0]  i,
                                                 input logic [SIZE_W-1:0] s);
      return (SIZE_W'(i) == s - SIZE_W'(1)) ? '0 : i + IDX_W'(1);
   endfunction

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [SIZE_W-1:0] ring_ff, ring_in;
   logic [SIZE_W-1:0] s_ff, s_in;
   logic [IDX_W-1:0]  src_ff, src_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SIZE_W-1:0] n_ff, n_in;
   logic              live_ff, live_in;
   logic [IDX_W-1:0]  nsel_ff, nsel_in;
   logic              phase_ff, phase_in;
   logic [IDX_W-1:0]  tmod_ff, tmod_in;
   logic [IDX_W-1:0]  rdist_ff, rdist_in;
   logic [SIZE_W-1:0] acc_ff, acc_in;
   logic              vld_ff, vld_in;
   logic [SIZE_W-1:0] cost_ff, cost_in;

   ent_type           tbl_mem [PT_COUNT];
   ent_type           rdata_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   ent_type           wr_data;
   logic [IDX_W-1:0]  rd_addr;

   logic              rem_start;
   logic [IDX_W-1:0]  rem_dividend;
   logic [SIZE_W-1:0] rem_divisor;
   logic              rem_done;
   logic [IDX_W-1:0]  rem_value;

   logic [SIZE_W-1:0] eff_size;
   logic              issue;
   logic [IDX_W-1:0]  lin_dist;
   logic [SIZE_W-1:0] odist;
   logic [IDX_W-1:0]  adiff;

   cmnc_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign eff_size = (ring_ff == '0) ? SIZE_W'(1) :
                     (ring_ff > SIZE_W'(PT_COUNT)) ? SIZE_W'(PT_COUNT) : ring_ff;
   assign issue    = (n_ff != s_ff);
   assign lin_dist = (tmod_ff >= tgt_ff) ? tmod_ff - tgt_ff : tgt_ff - tmod_ff;
   assign odist    = s_ff - SIZE_W'(lin_dist);
   assign adiff    = (rdist_ff >= nsel_ff) ? rdist_ff - nsel_ff : nsel_ff - rdist_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ring_in      = csr_valid ? csr_ring_size : ring_ff;
      s_in         = s_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      live_in      = 1'b0;
      nsel_in      = nsel_ff;
      phase_in     = phase_ff;
      tmod_in      = tmod_ff;
      rdist_in     = rdist_ff;
      acc_in       = acc_ff;
      vld_in       = 1'b0;
      cost_in      = cost_ff;
      rem_start    = 1'b0;
      rem_dividend = rdata_ff.target;
      rem_divisor  = s_ff;
      wr_en        = 1'b0;
      wr_addr      = req_source_index;
      wr_data      = '{valid: req_entry_mapped, target: req_entry_target};
      rd_addr      = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '0;
            idx_in  = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(PT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_WRITE) begin
                  wr_en = 1'b1;
               end else begin
                  cmd_in       = cmd_type'(req_command);
                  tgt_in       = req_target_index;
                  s_in         = eff_size;
                  acc_in       = '0;
                  phase_in     = 1'b0;
                  rem_start    = 1'b1;
                  rem_dividend = req_source_index;
                  rem_divisor  = eff_size;
                  state_in     = ST_MOD_SRC;
               end
            end
         end
         ST_MOD_SRC: begin
            if (rem_done) begin
               src_in       = rem_value;
               rem_start    = 1'b1;
               rem_dividend = tgt_ff;
               state_in     = ST_MOD_TGT;
            end
         end
         ST_MOD_TGT: begin
            if (rem_done) begin
               tgt_in = rem_value;
               if (cmd_ff == CMD_ADJ) begin
                  state_in = ST_ADJ_RD0;
               end else begin
                  idx_in   = (cmd_ff == CMD_BACK) ? ring_back(src_ff, s_ff)
                                                  : ring_fwd(src_ff, s_ff);
                  n_in     = SIZE_W'(1);
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_ADJ_RD0: begin
            rd_addr  = ring_back(src_ff, s_ff);
            state_in = ST_ADJ_CHK0;
         end
         ST_ADJ_CHK0: begin
            if (rdata_ff.valid) begin
               rem_start = 1'b1;
               nsel_in   = IDX_W'(1);
               state_in  = ST_MOD_ENT;
            end else begin
               state_in = ST_ADJ_RD1;
            end
         end
         ST_ADJ_RD1: begin
            phase_in = 1'b1;
            rd_addr  = ring_fwd(src_ff, s_ff);
            state_in = ST_ADJ_CHK1;
         end
         ST_ADJ_CHK1: begin
            if (rdata_ff.valid) begin
               rem_start = 1'b1;
               nsel_in   = IDX_W'(1);
               state_in  = ST_MOD_ENT;
            end else begin
               vld_in   = 1'b1;
               cost_in  = acc_ff;
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            rd_addr = idx_ff;
            if (live_ff && rdata_ff.valid) begin
               rem_start = 1'b1;
               nsel_in   = IDX_W'(n_ff - SIZE_W'(1));
               state_in  = ST_MOD_ENT;
            end else if (!issue && !live_ff) begin
               vld_in   = 1'b1;
               cost_in  = '0;
               state_in = ST_IDLE;
            end else begin
               live_in = issue;
               if (issue) begin
                  idx_in = (cmd_ff == CMD_BACK) ? ring_back(idx_ff, s_ff)
                                                : ring_fwd(idx_ff, s_ff);
                  n_in   = n_ff + SIZE_W'(1);
               end
            end
         end
         ST_MOD_ENT: begin
            if (rem_done) begin
               tmod_in  = rem_value;
               state_in = ST_COST_RD;
            end
         end
         ST_COST_RD: begin
            rdist_in = (SIZE_W'(lin_dist) < odist) ? lin_dist : IDX_W'(odist);
            state_in = ST_COST_ACC;
         end
         ST_COST_ACC: begin
            acc_in = acc_ff + SIZE_W'(adiff);
            if (cmd_ff == CMD_ADJ && !phase_ff) begin
               state_in = ST_ADJ_RD1;
            end else begin
               vld_in   = 1'b1;
               cost_in  = acc_ff + SIZE_W'(adiff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ring_ff  <= SIZE_W'(PT_COUNT);
         idx_ff   <= '0;
         live_ff  <= 1'b0;
         vld_ff   <= 1'b0;
         n_ff     <= SIZE_W'(1);
         s_ff     <= SIZE_W'(PT_COUNT);
      end else begin
         state_ff <= state_in;
         ring_ff  <= ring_in;
         idx_ff   <= idx_in;
         live_ff  <= live_in;
         vld_ff   <= vld_in;
         n_ff     <= n_in;
         s_ff     <= s_in;
      end
      cmd_ff   <= cmd_in;
      src_ff   <= src_in;
      tgt_ff   <= tgt_in;
      nsel_ff  <= nsel_in;
      phase_ff <= phase_in;
      tmod_ff  <= tmod_in;
      rdist_ff <= rdist_in;
      acc_ff   <= acc_in;
      cost_ff  <= cost_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= tbl_mem[rd_addr];
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff;
   assign rsp_cost  = cost_ff;

   // result beats only leave as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_WRITE) |=> !rsp_valid)
      else $error("write beat produced a result");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (n_ff <= s_ff && s_ff != '0))
      else $error("search step beyond ring size");

   a_cost_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cost <= SIZE_W'(PT_COUNT)))
      else $error("cost out of range");

endmodule

@@ tb/tb_contour_mapping_neighbor_cost.sv @@
// ----------------------------------------------------------------------------
// tb_contour_mapping_neighbor_cost: self-checking bench for the neighbor cost
// Fills the mapping table with write beats and fires adjacent, backward and
// forward cost queries over a range of ring sizes (zero, two, full and
// oversized among them). A shadow table and ring size in the bench predict
// each cost when the query is taken; every rsp_valid beat is checked against
// the oldest predicted cost. Sender gaps are random, with one stretch with
// no gaps, and a stall watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_contour_mapping_neighbor_cost;
   import cmnc_pkg::*;

   localparam int STALL_LIMIT = 8000;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   logic [1:0]        req_command      = '0;
   logic [IDX_W-1:0]  req_source_index = '0;
   logic [IDX_W-1:0]  req_target_index = '0;
   logic              req_entry_mapped = 1'b0;
   logic [IDX_W-1:0]  req_entry_target = '0;
   logic              rsp_valid;
   logic [SIZE_W-1:0] rsp_cost;
   logic              csr_valid        = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_ring_size    = '0;

   logic              shadow_valid [PT_COUNT];
   logic [IDX_W-1:0]  shadow_target [PT_COUNT];
   logic [SIZE_W-1:0] shadow_ring;
   logic [SIZE_W-1:0] pending_costs [$];
   logic [SIZE_W-1:0] next_cost;
   int                err_count    = 0;
   int                stall_cycles = 0;
   bit                idle_on      = 1'b1;

   contour_mapping_neighbor_cost u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_source_index (req_source_index),
      .req_target_index (req_target_index),
      .req_entry_mapped (req_entry_mapped),
      .req_entry_target (req_entry_target),
      .rsp_valid        (rsp_valid),
      .rsp_cost         (rsp_cost),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_ring_size    (csr_ring_size)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned eff_ring();
      if (shadow_ring == 0) return 1;
      if (shadow_ring > PT_COUNT) return PT_COUNT;
      return shadow_ring;
   endfunction

   function automatic int unsigned ring_gap(int unsigned a, int unsigned b, int unsigned ring);
      int unsigned d;
      d = (a >= b) ? a - b : b - a;
      return (d < ring - d) ? d : ring - d;
   endfunction

   function automatic int unsigned abs_gap(int unsigned a, int unsigned b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [SIZE_W-1:0] predict_cost(cmd_type op, logic [IDX_W-1:0] src_in,
                                                      logic [IDX_W-1:0] tgt_in);
      int unsigned ring, src, tgt, idx, cost, step;
      bit          found;
      ring  = eff_ring();
      src   = src_in % ring;
      tgt   = tgt_in % ring;
      cost  = 0;
      found = 1'b0;
      if (op == CMD_ADJ) begin
         // both neighbors counted on their own, even when they coincide
         idx = (src + ring - 1) % ring;
         if (shadow_valid[idx])
            cost += abs_gap(ring_gap(shadow_target[idx] % ring, tgt, ring), 1);
         idx = (src + 1) % ring;
         if (shadow_valid[idx])
            cost += abs_gap(ring_gap(shadow_target[idx] % ring, tgt, ring), 1);
      end else begin
         for (step = 1; step < ring && !found; step++) begin
            idx = (op == CMD_BACK) ? (src + ring - step) % ring : (src + step) % ring;
            if (shadow_valid[idx]) begin
               found = 1'b1;
               cost  = abs_gap(ring_gap(shadow_target[idx] % ring, tgt, ring), step);
            end
         end
      end
      return cost[SIZE_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] pick_index(int unsigned ring);
      if ($urandom_range(99) < 85) return IDX_W'($urandom_range(ring - 1));
      return IDX_W'($urandom_range(PT_COUNT - 1));
   endfunction

   // start stays high after a taken beat; the next call either drops it for a random gap or drives the next beat
   task automatic send_item(cmd_type op, logic [IDX_W-1:0] src, logic [IDX_W-1:0] tgt,
                            logic mapped, logic [IDX_W-1:0] etgt);
      if (idle_on) begin
         while ($urandom_range(99) < 22) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start            <= 1'b1;
      req_command      <= op;
      req_source_index <= src;
      req_target_index <= tgt;
      req_entry_mapped <= mapped;
      req_entry_target <= etgt;
      do @(posedge clock); while (busy);
      if (op == CMD_WRITE) begin
         shadow_valid[src]  = mapped;
         shadow_target[src] = etgt;
      end else begin
         pending_costs.push_back(predict_cost(op, src, tgt));
      end
   endtask

   task automatic quiesce();
      start <= 1'b0;
      do @(posedge clock); while (pending_costs.size() != 0 || busy);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_ring(logic [SIZE_W-1:0] value);
      quiesce();
      csr_valid     <= 1'b1;
      csr_ring_size <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_ring = value;
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(logic [SIZE_W-1:0] size_val, int count, bit pause_mid);
      int unsigned ring;
      cmd_type     op;
      set_ring(size_val);
      ring = eff_ring();
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) quiesce();
         if ($urandom_range(99) < 45) op = CMD_WRITE;
         else op = cmd_type'($urandom_range(CMD_FWD, CMD_ADJ));
         send_item(op, pick_index(ring), pick_index(ring), $urandom_range(99) < 80,
                   pick_index(ring));
      end
   endtask

   task automatic test_empty_table();
      send_item(CMD_ADJ, 0, 0, 1'b0, 0);
      send_item(CMD_BACK, 1023, 1023, 1'b0, 0);
      send_item(CMD_FWD, 0, 512, 1'b0, 0);
   endtask

   task automatic test_small_ring();
      set_ring(8);
      send_item(CMD_WRITE, 0, 0, 1'b1, 0);
      send_item(CMD_WRITE, 7, 0, 1'b1, 1023);   // stored target outside ring
      send_item(CMD_WRITE, 2, 0, 1'b0, 3);
      send_item(CMD_WRITE, 500, 0, 1'b1, 5);    // beyond ring, kept but unread
      send_item(CMD_ADJ, 1023, 1023, 1'b0, 0);
      send_item(CMD_BACK, 2, 0, 1'b0, 0);
      send_item(CMD_FWD, 4, 2, 1'b1, 1023);
      send_item(CMD_FWD, 1, 7, 1'b0, 0);
   endtask

   task automatic test_ring_extremes();
      set_ring(0);
      send_item(CMD_ADJ, 5, 9, 1'b0, 0);
      send_item(CMD_BACK, 0, 0, 1'b0, 0);
      set_ring(2);
      send_item(CMD_WRITE, 1, 0, 1'b1, 1023);
      send_item(CMD_ADJ, 0, 1, 1'b0, 0);
      send_item(CMD_FWD, 1, 0, 1'b0, 0);
      set_ring(2047);
      send_item(CMD_BACK, 0, 0, 1'b0, 0);
      send_item(CMD_FWD, 1023, 1023, 1'b0, 0);
      set_ring(1024);
      send_item(CMD_WRITE, 1023, 0, 1'b1, 0);
      send_item(CMD_ADJ, 0, 512, 1'b0, 0);
   endtask

   task automatic test_small_rings();
      for (int k = 0; k < 7; k++)
         run_phase(SIZE_W'($urandom_range(16, 1)), 40, 1'b0);
   endtask

   task automatic test_medium_rings();
      run_phase(SIZE_W'($urandom_range(300, 17)), 40, 1'b0);
      idle_on = 1'b0;
      run_phase(SIZE_W'($urandom_range(300, 17)), 40, 1'b0);
      idle_on = 1'b1;
      run_phase(SIZE_W'($urandom_range(300, 17)), 40, 1'b0);
   endtask

   task automatic test_large_rings();
      run_phase(1024, 40, 1'b0);
      run_phase(SIZE_W'($urandom_range(2047, 1025)), 20, 1'b0);
   endtask

   task automatic test_drain_pause();
      run_phase(SIZE_W'($urandom_range(32, 3)), 40, 1'b1);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_costs.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual cost %0d",
                     $time, rsp_cost);
            err_count++;
         end else begin
            next_cost = pending_costs.pop_front();
            if (rsp_cost !== next_cost) begin
               $display("%0t: cost mismatch, expected %0d, actual %0d",
                        $time, next_cost, rsp_cost);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, stall_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < PT_COUNT; i++) begin
         shadow_valid[i]  = 1'b0;
         shadow_target[i] = '0;
      end
      shadow_ring = 1024;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_small_ring();
      test_ring_extremes();
      test_small_rings();
      test_medium_rings();
      test_large_rings();
      test_drain_pause();
      quiesce();
      repeat (60) @(posedge clock);
      if (pending_costs.size() != 0) begin
         $display("%0t: %0d expected costs never arrived", $time, pending_costs.size());
      end
      if (err_count == 0 && pending_costs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
